/* src/impact_parameter_chi2_defines.svh */
// Assertion helpers for the RTL files; ipchi_back includes them.
`ifndef IMPACT_PARAMETER_CHI2_DEFINES_SVH
`define IMPACT_PARAMETER_CHI2_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition: %m");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* src/ipchi_pkg.sv */
package ipchi_pkg;

   localparam int FRAC_BITS_DEF = 24;
   localparam int WORD_BITS_DEF = 48;
   localparam int IN_BITS = 48;
   localparam int CHI_BITS = 48;
   localparam int STATUS_BITS = 2;
   localparam int SLOT_BITS = 5;
   localparam int NUM_SLOTS = 24;
   localparam int ADDR_BITS = 5;
   localparam int PROG_LEN = 58;
   localparam int PC_BITS = 6;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SATURATED = 2'd2;

   // Operand slots.
   localparam logic [ADDR_BITS-1:0] SL_X = 5'd0;
   localparam logic [ADDR_BITS-1:0] SL_Y = 5'd1;
   localparam logic [ADDR_BITS-1:0] SL_Z = 5'd2;
   localparam logic [ADDR_BITS-1:0] SL_TX = 5'd3;
   localparam logic [ADDR_BITS-1:0] SL_TY = 5'd4;
   localparam logic [ADDR_BITS-1:0] SL_C00 = 5'd5;
   localparam logic [ADDR_BITS-1:0] SL_C10 = 5'd6;
   localparam logic [ADDR_BITS-1:0] SL_C11 = 5'd7;
   localparam logic [ADDR_BITS-1:0] SL_C20 = 5'd8;
   localparam logic [ADDR_BITS-1:0] SL_C21 = 5'd9;
   localparam logic [ADDR_BITS-1:0] SL_C22 = 5'd10;
   localparam logic [ADDR_BITS-1:0] SL_C30 = 5'd11;
   localparam logic [ADDR_BITS-1:0] SL_C31 = 5'd12;
   localparam logic [ADDR_BITS-1:0] SL_C32 = 5'd13;
   localparam logic [ADDR_BITS-1:0] SL_C33 = 5'd14;
   localparam logic [ADDR_BITS-1:0] SL_VX = 5'd15;
   localparam logic [ADDR_BITS-1:0] SL_VY = 5'd16;
   localparam logic [ADDR_BITS-1:0] SL_VZ = 5'd17;
   localparam logic [ADDR_BITS-1:0] SL_V00 = 5'd18;
   localparam logic [ADDR_BITS-1:0] SL_V10 = 5'd19;
   localparam logic [ADDR_BITS-1:0] SL_V11 = 5'd20;
   localparam logic [ADDR_BITS-1:0] SL_V20 = 5'd21;
   localparam logic [ADDR_BITS-1:0] SL_V21 = 5'd22;
   localparam logic [ADDR_BITS-1:0] SL_V22 = 5'd23;

   // Scratch words above the operand slots.
   localparam logic [ADDR_BITS-1:0] T0 = 5'd24;
   localparam logic [ADDR_BITS-1:0] T1 = 5'd25;
   localparam logic [ADDR_BITS-1:0] T2 = 5'd26;
   localparam logic [ADDR_BITS-1:0] T3 = 5'd27;
   localparam logic [ADDR_BITS-1:0] T4 = 5'd28;
   localparam logic [ADDR_BITS-1:0] T5 = 5'd29;
   localparam logic [ADDR_BITS-1:0] T6 = 5'd30;
   localparam logic [ADDR_BITS-1:0] T7 = 5'd31;

   typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_type;

   typedef struct packed {
      op_type op;
      logic [ADDR_BITS-1:0] src_a;
      logic [ADDR_BITS-1:0] src_b;
      logic [ADDR_BITS-1:0] dst;
   } uop_type;

   // Classified input word as it travels from the front to the back.
   typedef struct packed {
      logic slot_ok;
      logic [SLOT_BITS-1:0] slot;
      logic last;
   } cmd_type;

   function automatic uop_type uop(op_type op, logic [ADDR_BITS-1:0] a,
                                   logic [ADDR_BITS-1:0] b, logic [ADDR_BITS-1:0] d);
      uop_type u;
      u.op = op;
      u.src_a = a;
      u.src_b = b;
      u.dst = d;
      return u;
   endfunction

   // Microprogram: extrapolation, residual covariance, determinant, numerator, divide.
   function automatic uop_type ucode(logic [PC_BITS-1:0] pc);
      uop_type u;
      case (pc)
         6'd0: u = uop(OP_SUB, SL_VZ, SL_Z, T0);
         6'd1: u = uop(OP_MUL, T0, SL_TX, T1);
         6'd2: u = uop(OP_ADD, SL_X, T1, T1);
         6'd3: u = uop(OP_SUB, T1, SL_VX, T1);
         6'd4: u = uop(OP_MUL, T0, SL_TY, T2);
         6'd5: u = uop(OP_ADD, SL_Y, T2, T2);
         6'd6: u = uop(OP_SUB, T2, SL_VY, T2);
         6'd7: u = uop(OP_MUL, T0, T0, T3);
         6'd8: u = uop(OP_ADD, SL_V00, SL_C00, T4);
         6'd9: u = uop(OP_MUL, T3, SL_C22, T5);
         6'd10: u = uop(OP_MUL, T0, SL_C20, T6);
         6'd11: u = uop(OP_ADD, T6, T6, T6);
         6'd12: u = uop(OP_ADD, T5, T6, T5);
         6'd13: u = uop(OP_ADD, T4, T5, T4);
         6'd14: u = uop(OP_ADD, SL_V10, SL_C10, T5);
         6'd15: u = uop(OP_MUL, T3, SL_C32, T6);
         6'd16: u = uop(OP_ADD, SL_C30, SL_C21, T7);
         6'd17: u = uop(OP_MUL, T0, T7, T7);
         6'd18: u = uop(OP_ADD, T6, T7, T6);
         6'd19: u = uop(OP_ADD, T5, T6, T5);
         6'd20: u = uop(OP_ADD, SL_V11, SL_C11, T6);
         6'd21: u = uop(OP_MUL, T3, SL_C33, T7);
         6'd22: u = uop(OP_MUL, T0, SL_C31, T3);
         6'd23: u = uop(OP_ADD, T3, T3, T3);
         6'd24: u = uop(OP_ADD, T7, T3, T7);
         6'd25: u = uop(OP_ADD, T6, T7, T6);
         6'd26: u = uop(OP_MUL, SL_TX, SL_TX, T0);
         6'd27: u = uop(OP_MUL, T0, SL_V22, T0);
         6'd28: u = uop(OP_MUL, SL_TX, SL_V20, T3);
         6'd29: u = uop(OP_ADD, T3, T3, T3);
         6'd30: u = uop(OP_SUB, T0, T3, T0);
         6'd31: u = uop(OP_ADD, T4, T0, T4);
         6'd32: u = uop(OP_MUL, SL_TX, SL_TY, T0);
         6'd33: u = uop(OP_MUL, T0, SL_V22, T0);
         6'd34: u = uop(OP_MUL, SL_TY, SL_V20, T3);
         6'd35: u = uop(OP_SUB, T0, T3, T0);
         6'd36: u = uop(OP_MUL, SL_TX, SL_V21, T3);
         6'd37: u = uop(OP_SUB, T0, T3, T0);
         6'd38: u = uop(OP_ADD, T5, T0, T5);
         6'd39: u = uop(OP_MUL, SL_TY, SL_TY, T0);
         6'd40: u = uop(OP_MUL, T0, SL_V22, T0);
         6'd41: u = uop(OP_MUL, SL_TY, SL_V21, T3);
         6'd42: u = uop(OP_ADD, T3, T3, T3);
         6'd43: u = uop(OP_SUB, T0, T3, T0);
         6'd44: u = uop(OP_ADD, T6, T0, T6);
         6'd45: u = uop(OP_MUL, T4, T6, T0);
         6'd46: u = uop(OP_MUL, T5, T5, T3);
         6'd47: u = uop(OP_SUB, T0, T3, T0);
         6'd48: u = uop(OP_MUL, T1, T1, T3);
         6'd49: u = uop(OP_MUL, T3, T6, T3);
         6'd50: u = uop(OP_MUL, T1, T2, T7);
         6'd51: u = uop(OP_MUL, T7, T5, T7);
         6'd52: u = uop(OP_ADD, T7, T7, T7);
         6'd53: u = uop(OP_SUB, T3, T7, T3);
         6'd54: u = uop(OP_MUL, T2, T2, T7);
         6'd55: u = uop(OP_MUL, T7, T4, T7);
         6'd56: u = uop(OP_ADD, T3, T7, T3);
         default: u = uop(OP_DIV, T3, T0, T0);
      endcase
      return u;
   endfunction

endpackage

/* src/ipchi_front.sv */
module ipchi_front #(
   parameter int WORD_BITS = ipchi_pkg::WORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [ipchi_pkg::SLOT_BITS-1:0] req_slot,
   input  logic [ipchi_pkg::IN_BITS-1:0] req_value,
   input  logic req_last,
   output logic head_valid,
   output ipchi_pkg::cmd_type head_cmd,
   output logic [WORD_BITS-1:0] head_value,
   input  logic head_pop
);

   localparam int W = WORD_BITS;
   localparam int EW = ((ipchi_pkg::IN_BITS > W) ? ipchi_pkg::IN_BITS : W) + 1;

   logic signed [EW-1:0] val_ext;
   logic signed [EW-1:0] wmax_ext;
   logic signed [EW-1:0] wmin_ext;
   logic [W-1:0] val_clamp;
   ipchi_pkg::cmd_type cmd;
   logic push_ok;

   ipchi_pkg::cmd_type ent_cmd_ff [2];
   logic [W-1:0] ent_val_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Clamp the operand to the word range and mark slots that do not exist.
   always_comb begin
      val_ext = EW'($signed(req_value));
      wmax_ext = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
      wmin_ext = ~wmax_ext;
      if (val_ext > wmax_ext) begin
         val_clamp = wmax_ext[W-1:0];
      end else if (val_ext < wmin_ext) begin
         val_clamp = wmin_ext[W-1:0];
      end else begin
         val_clamp = val_ext[W-1:0];
      end
      cmd.slot_ok = (req_slot < ipchi_pkg::SLOT_BITS'(ipchi_pkg::NUM_SLOTS));
      cmd.slot = req_slot;
      cmd.last = req_last;
   end

   // Two-word queue toward the back.
   assign req_full = (count_ff == 2'd2);
   assign push_ok = req_push && !req_full;
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd = ent_cmd_ff[rd_ptr_ff];
   assign head_value = ent_val_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ (head_pop && head_valid);
      count_in = count_ff + 2'(push_ok) - 2'(head_pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ent_cmd_ff[wr_ptr_ff] <= cmd;
         ent_val_ff[wr_ptr_ff] <= val_clamp;
      end
   end

endmodule

/* src/ipchi_back.sv */
`include "impact_parameter_chi2_defines.svh"

module ipchi_back #(
   parameter int WORD_BITS = ipchi_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = ipchi_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  ipchi_pkg::cmd_type head_cmd,
   input  logic [WORD_BITS-1:0] head_value,
   output logic head_pop,
   input  logic rsp_pop,
   output logic rsp_empty,
   output logic [ipchi_pkg::CHI_BITS-1:0] rsp_chi_square,
   output logic [ipchi_pkg::STATUS_BITS-1:0] rsp_status
);

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int HB = (W + 1) / 2;
   localparam int LB = W - HB;
   localparam int PW = 2 * W;
   localparam int MW = 2 * W - F + 1;
   localparam int QW = W + F;
   localparam int DCW = $clog2(QW);
   localparam int CB = ipchi_pkg::CHI_BITS;
   localparam int EXTW = ((QW > CB) ? QW : CB) + 1;
   localparam int NENT = 2 ** ipchi_pkg::ADDR_BITS;
   localparam logic [ipchi_pkg::PC_BITS-1:0] PC_LAST =
      ipchi_pkg::PC_BITS'(ipchi_pkg::PROG_LEN - 1);
   localparam logic [DCW-1:0] DIV_LAST = DCW'(QW - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_MUL, S_MULFIN, S_DIV, S_DIVFIN
   } state_type;

   state_type state_ff;
   logic [ipchi_pkg::PC_BITS-1:0] pc_ff;
   logic ovf_ff;
   logic [1:0] mcnt_ff;
   logic [PW-1:0] acc_ff;
   logic [W-1:0] mag_a_ff, mag_b_ff;
   logic neg_ff;
   logic [W:0] rem_ff;
   logic [QW-1:0] quo_ff, dvd_ff;
   logic [DCW-1:0] dcnt_ff;
   logic out_valid_ff;
   logic [CB-1:0] out_chi_ff;
   logic [ipchi_pkg::STATUS_BITS-1:0] out_status_ff;

   logic [W-1:0] mem [NENT];
   logic [NENT-1:0] vld_ff;
   logic [W-1:0] rd_a_ff, rd_b_ff;
   logic mem_we;
   logic [ipchi_pkg::ADDR_BITS-1:0] mem_wa;
   logic [W-1:0] mem_wd;

   ipchi_pkg::uop_type u;
   logic [W:0] alu_r;
   logic alu_ov;
   logic [W-1:0] alu_res;
   logic [W-1:0] wmax_w, wmin_w;
   logic [HB-1:0] mx, my;
   logic [2*HB-1:0] pp;
   logic [PW-1:0] pp_sh;
   logic [MW-2:0] mq;
   logic [MW-1:0] mq1;
   logic m_rem, mul_ov;
   logic [W-1:0] mul_res;
   logic [W:0] div_sh;
   logic div_ge;
   logic [EXTW-1:0] quo_ext, chi_max_ext;
   logic det_le, num_le;

   assign u = ipchi_pkg::ucode(pc_ff);
   assign wmax_w = {1'b0, {(W-1){1'b1}}};
   assign wmin_w = ~wmax_w;

   // Saturating add and subtract.
   always_comb begin
      if (u.op == ipchi_pkg::OP_SUB) begin
         alu_r = {rd_a_ff[W-1], rd_a_ff} - {rd_b_ff[W-1], rd_b_ff};
      end else begin
         alu_r = {rd_a_ff[W-1], rd_a_ff} + {rd_b_ff[W-1], rd_b_ff};
      end
      alu_ov = alu_r[W] != alu_r[W-1];
      if (alu_ov) begin
         alu_res = alu_r[W] ? wmin_w : wmax_w;
      end else begin
         alu_res = alu_r[W-1:0];
      end
   end

   // One half-word partial product per cycle.
   always_comb begin
      mx = mcnt_ff[1] ? HB'(mag_a_ff[W-1:HB]) : mag_a_ff[HB-1:0];
      my = mcnt_ff[0] ? HB'(mag_b_ff[W-1:HB]) : mag_b_ff[HB-1:0];
      pp = mx * my;
      case (mcnt_ff)
         2'd0: pp_sh = PW'(pp);
         2'd1, 2'd2: pp_sh = PW'(pp) << HB;
         default: pp_sh = PW'(pp) << (2 * HB);
      endcase
   end

   // Drop the fraction bits, round toward minus infinity and saturate.
   always_comb begin
      mq = acc_ff[PW-1:F];
      m_rem = |acc_ff[F-1:0];
      mq1 = {1'b0, mq} + MW'(m_rem);
      if (neg_ff) begin
         mul_ov = mq1 > (MW'(wmax_w) + MW'(1));
         mul_res = mul_ov ? wmin_w : (W'(0) - mq1[W-1:0]);
      end else begin
         mul_ov = mq > (MW-1)'(wmax_w);
         mul_res = mul_ov ? wmax_w : mq[W-1:0];
      end
   end

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      div_sh = {rem_ff[W-1:0], dvd_ff[QW-1]};
      div_ge = div_sh >= {1'b0, rd_b_ff};
      quo_ext = EXTW'(quo_ff);
      chi_max_ext = {{(EXTW-CB){1'b0}}, {CB{1'b1}}};
      det_le = rd_b_ff[W-1] || (rd_b_ff == '0);
      num_le = rd_a_ff[W-1] || (rd_a_ff == '0);
   end

   assign head_pop = (state_ff == S_IDLE) && head_valid;

   // Write port of the operand and scratch store.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = head_cmd.slot;
      mem_wd = head_value;
      case (state_ff)
         S_IDLE: mem_we = head_valid && head_cmd.slot_ok;
         S_EXEC: begin
            if (u.op inside {ipchi_pkg::OP_ADD, ipchi_pkg::OP_SUB}) begin
               mem_we = 1'b1;
               mem_wa = u.dst;
               mem_wd = alu_res;
            end
         end
         S_MULFIN: begin
            mem_we = 1'b1;
            mem_wa = u.dst;
            mem_wd = mul_res;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // Store with registered reads; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= vld_ff[u.src_a] ? mem[u.src_a] : '0;
      rd_b_ff <= vld_ff[u.src_b] ? mem[u.src_b] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_wa] <= 1'b1;
      end
   end

   // Sequencer over the shared adder, multiplier and divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         ovf_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (head_valid && head_cmd.last) begin
                  pc_ff <= '0;
                  ovf_ff <= 1'b0;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               case (u.op)
                  ipchi_pkg::OP_ADD, ipchi_pkg::OP_SUB: begin
                     ovf_ff <= ovf_ff | alu_ov;
                     pc_ff <= pc_ff + ipchi_pkg::PC_BITS'(1);
                     state_ff <= S_READ;
                  end
                  ipchi_pkg::OP_MUL: begin
                     mag_a_ff <= rd_a_ff[W-1] ? (W'(0) - rd_a_ff) : rd_a_ff;
                     mag_b_ff <= rd_b_ff[W-1] ? (W'(0) - rd_b_ff) : rd_b_ff;
                     neg_ff <= rd_a_ff[W-1] ^ rd_b_ff[W-1];
                     acc_ff <= '0;
                     mcnt_ff <= 2'd0;
                     state_ff <= S_MUL;
                  end
                  default: begin
                     // The result register must be free before the final step.
                     if (!out_valid_ff) begin
                        if (det_le) begin
                           out_chi_ff <= '0;
                           out_status_ff <= ipchi_pkg::STATUS_SINGULAR;
                           out_valid_ff <= 1'b1;
                           state_ff <= S_IDLE;
                        end else if (num_le) begin
                           out_chi_ff <= '0;
                           out_status_ff <= ovf_ff ? ipchi_pkg::STATUS_SATURATED
                                                   : ipchi_pkg::STATUS_OK;
                           out_valid_ff <= 1'b1;
                           state_ff <= S_IDLE;
                        end else begin
                           rem_ff <= '0;
                           quo_ff <= '0;
                           dvd_ff <= {rd_a_ff, {F{1'b0}}};
                           dcnt_ff <= '0;
                           state_ff <= S_DIV;
                        end
                     end
                  end
               endcase
            end
            S_MUL: begin
               acc_ff <= acc_ff + pp_sh;
               mcnt_ff <= mcnt_ff + 2'd1;
               if (mcnt_ff == 2'd3) begin
                  state_ff <= S_MULFIN;
               end
            end
            S_MULFIN: begin
               ovf_ff <= ovf_ff | mul_ov;
               pc_ff <= pc_ff + ipchi_pkg::PC_BITS'(1);
               state_ff <= S_READ;
            end
            S_DIV: begin
               rem_ff <= div_ge ? (div_sh - {1'b0, rd_b_ff}) : div_sh;
               quo_ff <= {quo_ff[QW-2:0], div_ge};
               dvd_ff <= {dvd_ff[QW-2:0], 1'b0};
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DIV_LAST) begin
                  state_ff <= S_DIVFIN;
               end
            end
            S_DIVFIN: begin
               if (quo_ext > chi_max_ext) begin
                  out_chi_ff <= {CB{1'b1}};
                  out_status_ff <= ipchi_pkg::STATUS_SATURATED;
               end else begin
                  out_chi_ff <= quo_ext[CB-1:0];
                  out_status_ff <= ovf_ff ? ipchi_pkg::STATUS_SATURATED
                                          : ipchi_pkg::STATUS_OK;
               end
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_chi_square = out_chi_ff;
   assign rsp_status = out_status_ff;

   // The low half of a split operand must cover at least the high half.
   localparam bit HALVES_OK = (LB <= HB);

   `ASSERT_NEVER(a_pop_only_idle, clock, reset, head_pop && (state_ff != S_IDLE))
   `ASSERT_NEVER(a_pc_range, clock, reset, (pc_ff > PC_LAST) || !HALVES_OK)
   `ASSERT_PROP(a_div_ends, clock, reset, (state_ff == S_DIV && dcnt_ff == DIV_LAST) |=> (state_ff == S_DIVFIN))

endmodule

/* src/impact_parameter_chi2.sv */
// Impact-parameter chi-square of a straight track against a vertex.
// Operand words are taken at one per cycle, unless full, into a two-word queue.
// A word with last set runs a 58-step microprogram: 27 multiplies, 30 add/sub steps and
// a restoring divide of WORD_BITS+FRAC_BITS quotient bits.
// The adder, the single half-word (24x24) multiplier and the one-bit-per-cycle divider are shared.
// Synchronous active-high reset makes the operand store read as zero, empties both queues.
module impact_parameter_chi2 #(
   parameter int FRAC_BITS = ipchi_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = ipchi_pkg::WORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [ipchi_pkg::SLOT_BITS-1:0] req_slot,
   input  logic [ipchi_pkg::IN_BITS-1:0] req_value,
   input  logic req_last,
   output logic empty,
   input  logic pop,
   output logic [ipchi_pkg::CHI_BITS-1:0] rsp_chi_square,
   output logic [ipchi_pkg::STATUS_BITS-1:0] rsp_status
);

   logic head_valid;
   ipchi_pkg::cmd_type head_cmd;
   logic [WORD_BITS-1:0] head_value;
   logic head_pop;

   // Front: clamp, classify and queue operand words.
   ipchi_front #(
      .WORD_BITS(WORD_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(push),
      .req_full(full),
      .req_slot(req_slot),
      .req_value(req_value),
      .req_last(req_last),
      .head_valid(head_valid),
      .head_cmd(head_cmd),
      .head_value(head_value),
      .head_pop(head_pop)
   );

   // Back: operand store and the arithmetic sequencer.
   ipchi_back #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_cmd(head_cmd),
      .head_value(head_value),
      .head_pop(head_pop),
      .rsp_pop(pop),
      .rsp_empty(empty),
      .rsp_chi_square(rsp_chi_square),
      .rsp_status(rsp_status)
   );

endmodule
